>>> rtl/core/mpfb_pkg.sv
// Shared types and constants for the mono panel frame buffer packer.
// Holds command, result and job formats plus the back-end state encoding.
// No dependencies.
`timescale 1ns / 1ps

package mpfb_pkg;

	localparam int PANEL_WIDTH_DEF  = 400;
	localparam int PANEL_HEIGHT_DEF = 300;

	// Widest store address over the supported panel sizes (256 x 128 bytes)
	localparam int ADDR_W = 15;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] LUMA_THRESHOLD_RESET = 8'd78;

	localparam logic [1:0] FUNC_MONO = 2'd0;
	localparam logic [1:0] FUNC_RGB  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;
	localparam logic [1:0] FUNC_FILL = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_COORD = 2'd1;
	localparam logic [1:0] STATUS_INDEX = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [8:0]  x_coord;
		logic [8:0]  y_coord;
		logic [15:0] pixel_value;
		logic [13:0] byte_index;
	} mpfb_cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] status;
	} mpfb_result_t;

	typedef enum logic [1:0] {
		BOP_NONE,
		BOP_PIXEL,
		BOP_READ,
		BOP_FILL
	} mpfb_bop_t;

	typedef struct packed {
		mpfb_bop_t         op;
		logic [ADDR_W-1:0] addr;
		logic [2:0]        bit_sel;
		logic              set_bit;
		logic [7:0]        fill_byte;
		logic [1:0]        status;
	} mpfb_job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_FILL
	} mpfb_bstate_t;

endpackage

>>> rtl/core/mpfb_front.sv
// Front end: accepts commands, holds the luma threshold register and turns each
// command into a store job (address, bit, value, status) for the job queue.
// Depends on mpfb_pkg.
`timescale 1ns / 1ps

module mpfb_front #(
	parameter int PANEL_WIDTH  = mpfb_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = mpfb_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  mpfb_pkg::mpfb_cmd_t                    cmd,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [7:0]                             cfg_data,
	input  logic [$clog2(mpfb_pkg::QUEUE_DEPTH):0] q_count,
	output logic                                   push,
	output mpfb_pkg::mpfb_job_t                    job
);

	localparam int ROWS4       = (PANEL_HEIGHT + 3) / 4;
	localparam int COLS2       = (PANEL_WIDTH + 1) / 2;
	localparam int STORE_DEPTH = COLS2 * ROWS4;
	localparam int CNT_W       = $clog2(mpfb_pkg::QUEUE_DEPTH) + 1;

	mpfb_pkg::mpfb_cmd_t cmd_s1;
	logic                valid_s1;
	logic [7:0]          thr_q;

	logic        accept;
	logic        x_ok;
	logic        y_ok;
	logic        idx_ok;
	logic [8:0]  r_row;
	logic [15:0] addr_full;
	logic [7:0]  luma;
	logic        white;

	// Leave room for the command already held in the input stage
	assign busy      = (q_count + CNT_W'(valid_s1)) >= CNT_W'(mpfb_pkg::QUEUE_DEPTH);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign push      = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			thr_q    <= mpfb_pkg::LUMA_THRESHOLD_RESET;
		end else begin
			valid_s1 <= accept;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	always_comb begin
		x_ok      = {1'b0, cmd_s1.x_coord} < 10'(PANEL_WIDTH);
		y_ok      = {1'b0, cmd_s1.y_coord} < 10'(PANEL_HEIGHT);
		idx_ok    = 16'(cmd_s1.byte_index) < 16'(STORE_DEPTH);
		// Rows are mirrored: count from the bottom of the panel
		r_row     = 9'(PANEL_HEIGHT - 1) - cmd_s1.y_coord;
		addr_full = 16'(cmd_s1.x_coord[8:1]) * 16'(ROWS4) + 16'(r_row[8:2]);
		luma      = 8'({cmd_s1.pixel_value[15:11], 1'b0}) + 8'(cmd_s1.pixel_value[10:5])
			+ 8'(cmd_s1.pixel_value[4:0]);
		white     = (cmd_s1.func == mpfb_pkg::FUNC_MONO) ? (|cmd_s1.pixel_value)
			: (luma >= thr_q);

		job.op        = mpfb_pkg::BOP_NONE;
		job.addr      = addr_full[mpfb_pkg::ADDR_W-1:0];
		job.bit_sel   = 3'd7 - {r_row[1:0], cmd_s1.x_coord[0]};
		job.set_bit   = white;
		job.fill_byte = cmd_s1.pixel_value[7:0];
		job.status    = mpfb_pkg::STATUS_OK;

		case (cmd_s1.func)
			mpfb_pkg::FUNC_MONO, mpfb_pkg::FUNC_RGB: begin
				if (x_ok && y_ok) begin
					job.op = mpfb_pkg::BOP_PIXEL;
				end else begin
					job.status = mpfb_pkg::STATUS_COORD;
				end
			end
			mpfb_pkg::FUNC_READ: begin
				job.addr = mpfb_pkg::ADDR_W'(cmd_s1.byte_index);
				if (idx_ok) begin
					job.op = mpfb_pkg::BOP_READ;
				end else begin
					job.status = mpfb_pkg::STATUS_INDEX;
				end
			end
			mpfb_pkg::FUNC_FILL: begin
				job.op = mpfb_pkg::BOP_FILL;
			end
			default: begin
				job.op = mpfb_pkg::BOP_NONE;
			end
		endcase
	end

endmodule

>>> rtl/core/mpfb_queue.sv
// Short job queue between the front and back ends of the frame buffer packer.
// Circular buffer of register entries with an occupancy count.
// Depends on mpfb_pkg.
`timescale 1ns / 1ps

module mpfb_queue (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  mpfb_pkg::mpfb_job_t                    push_job,
	input  logic                                   pop,
	output mpfb_pkg::mpfb_job_t                    head,
	output logic                                   empty,
	output logic [$clog2(mpfb_pkg::QUEUE_DEPTH):0] count
);

	localparam int DEPTH = mpfb_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	mpfb_pkg::mpfb_job_t entries_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign head  = entries_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> rtl/core/mpfb_back.sv
// Back end: owns the frame store memory and carries out queued jobs
// (bit read-modify-write, byte read, fill sweep), issuing one result per job.
// Depends on mpfb_pkg.
`timescale 1ns / 1ps

module mpfb_back #(
	parameter int PANEL_WIDTH  = mpfb_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = mpfb_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mpfb_pkg::mpfb_job_t    head,
	input  logic                   empty,
	output logic                   pop,
	output logic                   done,
	output mpfb_pkg::mpfb_result_t result
);

	localparam int ROWS4       = (PANEL_HEIGHT + 3) / 4;
	localparam int COLS2       = (PANEL_WIDTH + 1) / 2;
	localparam int STORE_DEPTH = COLS2 * ROWS4;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [7:0]             frame_store_q [STORE_DEPTH];
	logic [7:0]             rd_data_q;
	mpfb_pkg::mpfb_bstate_t state_q;
	mpfb_pkg::mpfb_bstate_t state_d;
	mpfb_pkg::mpfb_job_t    op_q;
	logic [AW-1:0]          fill_cnt_q;
	logic                   done_q;
	mpfb_pkg::mpfb_result_t result_q;

	logic                   fill_last;
	logic                   rd_en;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [7:0]             wr_data;
	logic [7:0]             sel_mask;
	logic                   res_valid_d;
	mpfb_pkg::mpfb_result_t res_d;

	assign fill_last = (fill_cnt_q == AW'(STORE_DEPTH - 1));
	assign done      = done_q;
	assign result    = result_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mpfb_pkg::BK_IDLE: begin
				if (!empty) begin
					state_d = (head.op == mpfb_pkg::BOP_FILL) ? mpfb_pkg::BK_FILL
						: mpfb_pkg::BK_EXEC;
				end
			end
			mpfb_pkg::BK_EXEC: begin
				state_d = mpfb_pkg::BK_IDLE;
			end
			mpfb_pkg::BK_FILL: begin
				if (fill_last) begin
					state_d = mpfb_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = mpfb_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop   = (state_q == mpfb_pkg::BK_IDLE) && !empty;
		rd_en = pop && (head.op inside {mpfb_pkg::BOP_PIXEL, mpfb_pkg::BOP_READ});

		sel_mask = 8'd1 << op_q.bit_sel;
		wr_en    = 1'b0;
		wr_addr  = op_q.addr[AW-1:0];
		wr_data  = op_q.set_bit ? (rd_data_q | sel_mask) : (rd_data_q & ~sel_mask);

		res_valid_d     = 1'b0;
		res_d.read_data = (op_q.op == mpfb_pkg::BOP_READ) ? rd_data_q : 8'd0;
		res_d.status    = op_q.status;

		case (state_q)
			mpfb_pkg::BK_EXEC: begin
				wr_en       = (op_q.op == mpfb_pkg::BOP_PIXEL);
				res_valid_d = 1'b1;
			end
			mpfb_pkg::BK_FILL: begin
				wr_en       = 1'b1;
				wr_addr     = fill_cnt_q;
				wr_data     = op_q.fill_byte;
				res_valid_d = fill_last;
			end
			default: begin
				wr_en       = 1'b0;
				res_valid_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mpfb_pkg::BK_IDLE;
			fill_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_valid_d;
			// Sweep one byte a cycle; park at zero outside a fill
			if (state_q == mpfb_pkg::BK_FILL && !fill_last) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end else begin
				fill_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
		if (res_valid_d) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_store_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= frame_store_q[head.addr[AW-1:0]];
		end
	end

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) != mpfb_pkg::BK_IDLE))
		else $error("result strobe without a job in progress");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty job queue");

	a_write_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == mpfb_pkg::BK_EXEC) |-> (op_q.status == mpfb_pkg::STATUS_OK))
		else $error("store written by a rejected transaction");

	a_fill_cnt_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mpfb_pkg::BK_FILL) |-> (fill_cnt_q == '0))
		else $error("fill counter moved outside a fill");

endmodule

>>> rtl/core/mono_panel_framebuffer_packer_top.sv
// Mono panel frame buffer packer: 1-bit frame store packed in 2x4 pixel bytes.
// Top level joining front end, job queue and back end.
// Depends on mpfb_pkg, mpfb_front, mpfb_queue, mpfb_back.
`timescale 1ns / 1ps

// A command is taken on a clock edge with start high and busy low. Every command
// returns exactly one result, shown on result for a single cycle with done high;
// the receiver cannot hold it off, so it must capture result whenever done is
// seen. Results keep command order. A pixel write or byte read occupies the
// back end for a store read and then the write or result, and the back end takes
// no new job until it is through with the last one. A fill sweeps the store
// one byte a cycle, all STORE_DEPTH bytes, 15000 at the default 400 x 300 panel.
// Commands wait in the input stage and a four-entry queue, which hold four at
// most between them; busy rises when that space is used up. The threshold
// register may be written at any time the block is idle and is always ready.

module mono_panel_framebuffer_packer_top #(
	parameter int PANEL_WIDTH  = mpfb_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = mpfb_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  mpfb_pkg::mpfb_cmd_t    cmd,
	output logic                   done,
	output mpfb_pkg::mpfb_result_t result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_data
);

	localparam int CNT_W = $clog2(mpfb_pkg::QUEUE_DEPTH) + 1;

	logic                q_push;
	mpfb_pkg::mpfb_job_t q_push_job;
	logic                q_pop;
	mpfb_pkg::mpfb_job_t q_head;
	logic                q_empty;
	logic [CNT_W-1:0]    q_count;

	mpfb_front #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.push      (q_push),
		.job       (q_push_job)
	);

	mpfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_push_job),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.count    (q_count)
	);

	mpfb_back #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (q_pop),
		.done   (done),
		.result (result)
	);

endmodule
